### src/lr_pkg.sv
// shared types, constants and helpers for the line rasterizer
`default_nettype none

package lr_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [1:0] REG_X_LIMIT      = 2'd1;
    localparam logic [1:0] REG_Y_LIMIT      = 2'd2;
    localparam int         CFG_INDEX_BITS   = 2;

    // clip limit after reset for coordinate widths of 6 bits or more
    localparam int LIMIT_RESET_VALUE = 32;

    // fractional error accumulator and the divider that seeds it
    localparam int FRAC_BITS  = 16;
    localparam int DIV_STEPS  = FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // queue depths between the parts
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    localparam int PIXEL_BITS = 24;
    localparam int GRAY_BITS  = 8;

    // how a line is stepped
    typedef enum logic [1:0] {
        KIND_AXIAL   = 2'd0,
        KIND_X_MAJOR = 2'd1,
        KIND_Y_MAJOR = 2'd2
    } line_kind_t;

    // stepper sequencer states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_DIV   = 2'd1,
        ST_FIRST = 2'd2,
        ST_STEP  = 2'd3
    } step_state_t;

    // gray level to packed pixel word
    function automatic logic [PIXEL_BITS-1:0] pack_pixel(
        input logic [GRAY_BITS-1:0] g,
        input logic                 fmt
    );
        logic [PIXEL_BITS-1:0] p;
        if (fmt)
        begin
            p = {g, g, g};
        end
        else
        begin
            p = {8'h00, g[7:3], g[7:2], g[7:3]};
        end
        return p;
    endfunction

endpackage

`default_nettype wire

### src/line_rasterizer_unit.sv
// line rasterizer top level: configuration registers, front, queues and stepper
// A straight line goes from the command queue through the stepper's first-point state
//   to the result queue; a line that needs the error accumulator first runs the bit-serial divider.
// Throughput: one point per cycle from the stepper while the result queue is not full. A
//   2-word command queue lets the next line be taken while one is being stepped.
// Reset: asynchronous, active low; queues empty, stepper idle, pixel_format 0, limits min(32, 2**(N-1)).
`default_nettype none

module line_rasterizer_unit #(
    parameter int COORD_BITS = 6
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration
    input  wire logic                         cfg_write,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [COORD_BITS-1:0]        cfg_data,
    // line commands
    input  wire logic                         push,
    output logic                              full,
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] end_x,
    input  wire logic signed [COORD_BITS-1:0] end_y,
    input  wire logic        [7:0]            gray,
    // points
    output logic                              empty,
    input  wire logic                         pop,
    output logic signed      [COORD_BITS-1:0] point_x,
    output logic signed      [COORD_BITS-1:0] point_y,
    output logic                              inside_res,
    output logic             [23:0]           pixel,
    output logic                              last
);
    import lr_pkg::*;

    localparam int N        = COORD_BITS;
    localparam int LIM_INT  = (N > 6) ? LIMIT_RESET_VALUE : (1 << (N - 1));
    localparam logic [N-1:0] LIM_RESET = N'(LIM_INT);
    localparam int CMD_W    = 6 * N + 3 + PIXEL_BITS;
    localparam int RES_W    = 2 * N + 2 + PIXEL_BITS;

    logic         pixel_format_reg;
    logic [N-1:0] x_limit_reg;
    logic [N-1:0] y_limit_reg;

    logic [N-1:0] f_first_x, f_first_y, f_far_x, f_far_y, f_major, f_minor;
    logic         f_x_neg;
    line_kind_t   f_kind;
    logic [23:0]  f_pixel;

    logic [CMD_W-1:0] cmd_wdata, cmd_rdata;
    logic             cmd_empty, cmd_pop;
    logic [N-1:0]     c_first_x, c_first_y, c_far_x, c_far_y, c_major, c_minor;
    logic             c_x_neg;
    logic [1:0]       c_kind_bits;
    logic [23:0]      c_pixel;

    logic             res_full, res_push;
    logic [N-1:0]     r_x, r_y;
    logic             r_inside, r_last;
    logic [23:0]      r_pixel;
    logic [RES_W-1:0] res_wdata, res_rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg <= 1'b0;
            x_limit_reg      <= LIM_RESET;
            y_limit_reg      <= LIM_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PIXEL_FORMAT: pixel_format_reg <= cfg_data[0];
                REG_X_LIMIT:      x_limit_reg      <= cfg_data;
                REG_Y_LIMIT:      y_limit_reg      <= cfg_data;
                default:          ;
            endcase
        end
    end

    // front: order and classify
    lr_front #(.COORD_BITS(N)) u_front (
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .gray         (gray),
        .pixel_format (pixel_format_reg),
        .first_x      (f_first_x),
        .first_y      (f_first_y),
        .far_x        (f_far_x),
        .far_y        (f_far_y),
        .x_neg        (f_x_neg),
        .major        (f_major),
        .minor        (f_minor),
        .kind         (f_kind),
        .pixel        (f_pixel)
    );

    // command queue between front and back
    assign cmd_wdata = {f_first_x, f_first_y, f_far_x, f_far_y, f_x_neg,
                        f_major, f_minor, f_kind, f_pixel};

    lr_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .wdata (cmd_wdata),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .rdata (cmd_rdata)
    );

    assign {c_first_x, c_first_y, c_far_x, c_far_y, c_x_neg,
            c_major, c_minor, c_kind_bits, c_pixel} = cmd_rdata;

    // back: divider and stepper
    lr_back #(.COORD_BITS(N)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_empty   (cmd_empty),
        .cmd_pop     (cmd_pop),
        .cmd_first_x (c_first_x),
        .cmd_first_y (c_first_y),
        .cmd_far_x   (c_far_x),
        .cmd_far_y   (c_far_y),
        .cmd_x_neg   (c_x_neg),
        .cmd_major   (c_major),
        .cmd_minor   (c_minor),
        .cmd_kind    (line_kind_t'(c_kind_bits)),
        .cmd_pixel   (c_pixel),
        .x_limit     (x_limit_reg),
        .y_limit     (y_limit_reg),
        .res_full    (res_full),
        .res_push    (res_push),
        .res_x       (r_x),
        .res_y       (r_y),
        .res_inside  (r_inside),
        .res_pixel   (r_pixel),
        .res_last    (r_last)
    );

    // result queue towards the consumer
    assign res_wdata = {r_x, r_y, r_inside, r_pixel, r_last};

    lr_fifo #(.WIDTH(RES_W), .DEPTH(RES_DEPTH)) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata (res_wdata),
        .pop   (pop),
        .empty (empty),
        .rdata (res_rdata)
    );

    assign {point_x, point_y, inside_res, pixel, last} = res_rdata;

endmodule

`default_nettype wire

### src/lr_fifo.sv
// small first-in first-out queue of words
`default_nettype none

module lr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic                  empty,
    output logic      [WIDTH-1:0] rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_write, do_read;

    // status and read port
    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign rdata    = mem_reg[rd_ptr_reg];
    assign do_write = push && !full;
    assign do_read  = pop && !empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_write ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_read ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_write && !do_read)
        begin
            count_next = count_reg + (AW+1)'(1);
        end
        else if (do_read && !do_write)
        begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // word storage
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

### src/lr_front.sv
// front part: orders endpoints, classifies the line and packs the pixel
`default_nettype none

module lr_front #(
    parameter int COORD_BITS = 6
) (
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] end_x,
    input  wire logic signed [COORD_BITS-1:0] end_y,
    input  wire logic        [7:0]            gray,
    input  wire logic                         pixel_format,
    output logic             [COORD_BITS-1:0] first_x,
    output logic             [COORD_BITS-1:0] first_y,
    output logic             [COORD_BITS-1:0] far_x,
    output logic             [COORD_BITS-1:0] far_y,
    output logic                              x_neg,
    output logic             [COORD_BITS-1:0] major,
    output logic             [COORD_BITS-1:0] minor,
    output lr_pkg::line_kind_t                kind,
    output logic             [23:0]           pixel
);
    import lr_pkg::*;

    localparam int N = COORD_BITS;

    logic         swap;
    logic [N:0]   dx_s;
    logic [N-1:0] adx;
    logic [N-1:0] ady;

    // top to bottom ordering and deltas
    always_comb
    begin
        swap    = start_y > end_y;
        first_x = swap ? end_x : start_x;
        first_y = swap ? end_y : start_y;
        far_x   = swap ? start_x : end_x;
        far_y   = swap ? start_y : end_y;
        dx_s    = {far_x[N-1], far_x} - {first_x[N-1], first_x};
        x_neg   = dx_s[N];
        adx     = x_neg ? N'(-dx_s) : dx_s[N-1:0];
        ady     = N'({far_y[N-1], far_y} - {first_y[N-1], first_y});
    end

    // line classification
    always_comb
    begin
        priority if (adx == '0 || ady == '0 || adx == ady)
        begin
            kind  = KIND_AXIAL;
            major = (adx > ady) ? adx : ady;
            minor = (adx > ady) ? ady : adx;
        end
        else if (ady > adx)
        begin
            kind  = KIND_Y_MAJOR;
            major = ady;
            minor = adx;
        end
        else
        begin
            kind  = KIND_X_MAJOR;
            major = adx;
            minor = ady;
        end
    end

    assign pixel = pack_pixel(gray, pixel_format);

endmodule

`default_nettype wire

### src/lr_back.sv
// back part: error increment divider and point stepper
`default_nettype none

module lr_back #(
    parameter int COORD_BITS = 6
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // command queue side
    input  wire logic                    cmd_empty,
    output logic                         cmd_pop,
    input  wire logic [COORD_BITS-1:0]   cmd_first_x,
    input  wire logic [COORD_BITS-1:0]   cmd_first_y,
    input  wire logic [COORD_BITS-1:0]   cmd_far_x,
    input  wire logic [COORD_BITS-1:0]   cmd_far_y,
    input  wire logic                    cmd_x_neg,
    input  wire logic [COORD_BITS-1:0]   cmd_major,
    input  wire logic [COORD_BITS-1:0]   cmd_minor,
    input  wire lr_pkg::line_kind_t      cmd_kind,
    input  wire logic [23:0]             cmd_pixel,
    // clip limits
    input  wire logic [COORD_BITS-1:0]   x_limit,
    input  wire logic [COORD_BITS-1:0]   y_limit,
    // result queue side
    input  wire logic                    res_full,
    output logic                         res_push,
    output logic      [COORD_BITS-1:0]   res_x,
    output logic      [COORD_BITS-1:0]   res_y,
    output logic                         res_inside,
    output logic      [23:0]             res_pixel,
    output logic                         res_last
);
    import lr_pkg::*;

    localparam int N = COORD_BITS;

    step_state_t          state_reg, state_next;
    logic [N-1:0]         cnt_reg, cnt_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [N-1:0]         cur_x_reg, cur_x_next;
    logic [N-1:0]         cur_y_reg, cur_y_next;
    logic [N-1:0]         end_x_reg, end_x_next;
    logic [N-1:0]         end_y_reg, end_y_next;
    logic                 x_neg_reg, x_neg_next;
    logic                 step_x_reg, step_x_next;
    logic                 step_y_reg, step_y_next;
    logic [N-1:0]         major_reg, major_next;
    line_kind_t           kind_reg, kind_next;
    logic [23:0]          pixel_reg, pixel_next;
    logic [N-1:0]         rem_reg, rem_next;
    logic [FRAC_BITS-1:0] adj_reg, adj_next;
    logic [FRAC_BITS-1:0] acc_reg, acc_next;

    logic [FRAC_BITS:0]   sum;
    logic                 carry;
    logic [N-1:0]         x_adv, y_adv;
    logic [N-1:0]         nx, ny;
    logic [N:0]           rem_shift;
    logic                 quo_bit;

    // candidate next point
    always_comb
    begin
        sum   = {1'b0, acc_reg} + {1'b0, adj_reg};
        carry = sum[FRAC_BITS];
        x_adv = x_neg_reg ? cur_x_reg - N'(1) : cur_x_reg + N'(1);
        y_adv = cur_y_reg + N'(1);
        unique case (kind_reg)
            KIND_AXIAL:
            begin
                nx = step_x_reg ? x_adv : cur_x_reg;
                ny = step_y_reg ? y_adv : cur_y_reg;
            end
            KIND_X_MAJOR:
            begin
                nx = x_adv;
                ny = carry ? y_adv : cur_y_reg;
            end
            KIND_Y_MAJOR:
            begin
                nx = carry ? x_adv : cur_x_reg;
                ny = y_adv;
            end
            default:
            begin
                nx = cur_x_reg;
                ny = cur_y_reg;
            end
        endcase
        // accumulated lines land exactly on the far endpoint
        if (kind_reg != KIND_AXIAL && cnt_reg == N'(1))
        begin
            nx = end_x_reg;
            ny = end_y_reg;
        end
    end

    // restoring divider step, one quotient bit a cycle
    always_comb
    begin
        rem_shift = {rem_reg, 1'b0};
        quo_bit   = rem_shift >= {1'b0, major_reg};
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        div_cnt_next = div_cnt_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        end_x_next   = end_x_reg;
        end_y_next   = end_y_reg;
        x_neg_next   = x_neg_reg;
        step_x_next  = step_x_reg;
        step_y_next  = step_y_reg;
        major_next   = major_reg;
        kind_next    = kind_reg;
        pixel_next   = pixel_reg;
        rem_next     = rem_reg;
        adj_next     = adj_reg;
        acc_next     = acc_reg;
        cmd_pop      = 1'b0;
        res_push     = 1'b0;
        res_x        = cur_x_reg;
        res_y        = cur_y_reg;
        res_last     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop      = 1'b1;
                    cur_x_next   = cmd_first_x;
                    cur_y_next   = cmd_first_y;
                    end_x_next   = cmd_far_x;
                    end_y_next   = cmd_far_y;
                    x_neg_next   = cmd_x_neg;
                    step_x_next  = cmd_far_x != cmd_first_x;
                    step_y_next  = cmd_far_y != cmd_first_y;
                    major_next   = cmd_major;
                    cnt_next     = cmd_major;
                    kind_next    = cmd_kind;
                    pixel_next   = cmd_pixel;
                    rem_next     = cmd_minor;
                    acc_next     = '0;
                    div_cnt_next = '0;
                    state_next   = (cmd_kind == KIND_AXIAL) ? ST_FIRST : ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next     = quo_bit ? N'(rem_shift - {1'b0, major_reg}) : N'(rem_shift);
                adj_next     = {adj_reg[FRAC_BITS-2:0], quo_bit};
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    res_last   = (cnt_reg == '0);
                    state_next = (cnt_reg == '0) ? ST_IDLE : ST_STEP;
                end
            end
            ST_STEP:
            begin
                res_x    = nx;
                res_y    = ny;
                res_last = (cnt_reg == N'(1));
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    cur_x_next = nx;
                    cur_y_next = ny;
                    acc_next   = sum[FRAC_BITS-1:0];
                    cnt_next   = cnt_reg - N'(1);
                    if (cnt_reg == N'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    // clip test on the word going out
    assign res_inside = !res_x[N-1] && !res_y[N-1] && (res_x < x_limit) && (res_y < y_limit);
    assign res_pixel  = pixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // line datapath
    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        div_cnt_reg <= div_cnt_next;
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        end_x_reg   <= end_x_next;
        end_y_reg   <= end_y_next;
        x_neg_reg   <= x_neg_next;
        step_x_reg  <= step_x_next;
        step_y_reg  <= step_y_next;
        major_reg   <= major_next;
        kind_reg    <= kind_next;
        pixel_reg   <= pixel_next;
        rem_reg     <= rem_next;
        adj_reg     <= adj_next;
        acc_reg     <= acc_next;
    end

endmodule

`default_nettype wire

### src/lr_checker.sv
// port-level checks for the line rasterizer, bound to the top level
`default_nettype none

module lr_checker #(
    parameter int COORD_BITS = 6
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  empty,
    input wire logic                  pop,
    input wire logic [COORD_BITS-1:0] point_x,
    input wire logic [COORD_BITS-1:0] point_y,
    input wire logic                  inside_res,
    input wire logic [23:0]           pixel,
    input wire logic                  last
);
    localparam int N = COORD_BITS;

    // no word is offered while in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result shown during reset");

    // a word not taken stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting word withdrawn");

    // a word not taken keeps its payload
    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(point_x) && $stable(point_y) && $stable(pixel)
                              && $stable(last) && $stable(inside_res)))
        else $error("waiting word changed");

    // inside points never have a negative coordinate
    a_inside_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && inside_res) |-> (!point_x[N-1] && !point_y[N-1]))
        else $error("negative point marked inside");

    // within a line y moves down by at most one and the pixel holds
    a_line_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last) ##1 !empty |->
            ((N'(point_y - $past(point_y)) == N'(0) ||
              N'(point_y - $past(point_y)) == N'(1)) && pixel == $past(pixel)))
        else $error("line points not adjacent");

endmodule

bind line_rasterizer_unit lr_checker #(.COORD_BITS(COORD_BITS)) u_lr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .point_x    (point_x),
    .point_y    (point_y),
    .inside_res (inside_res),
    .pixel      (pixel),
    .last       (last)
);

`default_nettype wire
